// ===== hw/rtl/hwcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwcs_pkg
// Types and character constants for the HTML whitespace and comment stripper.
// ----------------------------------------------------------------------------
package hwcs_pkg;

    localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_QUOTE = 8'h22;  // '"'
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam int unsigned MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // Bytes of the comment opener "<!--", by position.
    function automatic logic [7:0] opener_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = CHAR_LT;
            2'd1:    b = CHAR_BANG;
            default: b = CHAR_DASH;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/html_whitespace_comment_stripper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_whitespace_comment_stripper_unit
// Streaming HTML minifier: drops spaces in text and tag bodies, and whole comments.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_data : in_byte, in_last
//   m_      | out | m_valid / m_ready  | m_data : out_byte, run_last
//
// Each item is decoded in the cycle it is accepted; its 0..4 result bytes are
// loaded into a four-entry output buffer and leave at one per cycle while
// m_ready is high. An item giving at most one result sustains one item per
// cycle while m_ready is high; more results stall the input while the buffer drains.
// s_ready is high when the buffer is empty or its last byte is being taken.
// Reset (synchronous, aresetn low) returns to text mode with the buffer empty.
// ----------------------------------------------------------------------------
module html_whitespace_comment_stripper_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hwcs_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hwcs_pkg::out_item_t  m_data
);
    import hwcs_pkg::*;

    typedef enum logic [3:0] {
        MODE_TEXT    = 4'd0,
        MODE_KEYWORD = 4'd1,
        MODE_BODY    = 4'd2,
        MODE_QUOTE   = 4'd3,
        MODE_COMMENT = 4'd4,
        MODE_SKIP    = 4'd5
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  held_reg, held_next;
    logic [1:0]  dash_reg, dash_next;

    logic [7:0]  buf_reg [MAX_RESULTS];
    logic [2:0]  cnt_reg;

    logic [7:0]  res   [MAX_RESULTS];
    logic [2:0]  n_res;
    logic        accept, pop;

    assign accept  = s_valid && s_ready;
    assign m_valid = (cnt_reg != 3'd0);
    assign pop     = m_valid && m_ready;
    assign s_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_ready);
    assign m_data.out_byte = buf_reg[0];
    assign m_data.run_last = (cnt_reg == 3'd1);

    always_comb begin
        logic [7:0] b;
        logic       do_text;
        b         = s_data.in_byte;
        do_text   = 1'b0;
        mode_next = mode_reg;
        held_next = held_reg;
        dash_next = dash_reg;
        n_res     = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = 8'h00;
        end

        case (mode_reg)
            MODE_KEYWORD: begin
                res[n_res[1:0]] = b;
                n_res = n_res + 3'd1;
                if (b == CHAR_SPACE) begin
                    mode_next = MODE_BODY;
                end else if (b == CHAR_GT) begin
                    mode_next = MODE_TEXT;
                end
            end
            MODE_BODY: begin
                if (b == CHAR_QUOTE) begin
                    res[n_res[1:0]] = b;
                    n_res = n_res + 3'd1;
                    mode_next = MODE_QUOTE;
                end else if (b == CHAR_GT) begin
                    res[n_res[1:0]] = b;
                    n_res = n_res + 3'd1;
                    mode_next = MODE_TEXT;
                end else if (b != CHAR_SPACE) begin
                    res[n_res[1:0]] = b;
                    n_res = n_res + 3'd1;
                end
            end
            MODE_QUOTE: begin
                res[n_res[1:0]] = b;
                n_res = n_res + 3'd1;
                if (b == CHAR_QUOTE) begin
                    mode_next = MODE_BODY;
                end
            end
            MODE_COMMENT: begin
                if (b == CHAR_DASH) begin
                    if (dash_reg < 2'd2) begin
                        dash_next = dash_reg + 2'd1;
                    end
                end else if (b == CHAR_GT && dash_reg == 2'd2) begin
                    dash_next = 2'd0;
                    mode_next = MODE_SKIP;
                end else begin
                    dash_next = 2'd0;
                end
            end
            MODE_SKIP: begin
                if (!(b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR)) begin
                    do_text = 1'b1;
                end
            end
            default: begin
                do_text = 1'b1;
            end
        endcase

        if (do_text) begin
            mode_next = MODE_TEXT;
            if (held_reg != 2'd0) begin
                if (b == opener_byte(held_reg)) begin
                    if (held_reg == 2'd3) begin
                        held_next = 2'd0;
                        dash_next = 2'd2;
                        mode_next = MODE_COMMENT;
                    end else begin
                        held_next = held_reg + 2'd1;
                    end
                end else begin
                    // failed comment test: held bytes open a tag keyword
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < held_reg) begin
                            res[n_res[1:0]] = opener_byte(2'(k));
                            n_res = n_res + 3'd1;
                        end
                    end
                    held_next = 2'd0;
                    mode_next = MODE_KEYWORD;
                    res[n_res[1:0]] = b;
                    n_res = n_res + 3'd1;
                    if (b == CHAR_SPACE) begin
                        mode_next = MODE_BODY;
                    end else if (b == CHAR_GT) begin
                        mode_next = MODE_TEXT;
                    end
                end
            end else if (b == CHAR_LT) begin
                held_next = 2'd1;
            end else if (b != CHAR_SPACE) begin
                res[n_res[1:0]] = b;
                n_res = n_res + 3'd1;
            end
        end

        if (s_data.in_last) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < held_next) begin
                    res[n_res[1:0]] = opener_byte(2'(k));
                    n_res = n_res + 3'd1;
                end
            end
            mode_next = MODE_TEXT;
            held_next = 2'd0;
            dash_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            held_reg <= 2'd0;
            dash_reg <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                dash_reg <= dash_next;
                cnt_reg  <= n_res;
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    buf_reg[i] <= res[i];
                end
            end else if (pop) begin
                cnt_reg  <= cnt_reg - 3'd1;
                // head entry is always buf_reg[0]
                for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                    buf_reg[i] <= buf_reg[i + 1];
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(MAX_RESULTS))
        else $error("output buffer count out of range");

    a_held_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg != 2'd0) |-> (mode_reg == MODE_TEXT))
        else $error("opener bytes held outside text mode");

    a_dash_in_comment: assert property (@(posedge aclk) disable iff (!aresetn)
        (dash_reg != 2'd0) |-> (mode_reg == MODE_COMMENT))
        else $error("dash history set outside a comment");

    a_load_only_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && pop)))
        else $error("item accepted over undelivered results");

endmodule
